/* design/acv_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the arc vertex generator.
// Depends on nothing; every other file of the block but acv_if imports it.
package acv_pkg;

    localparam logic [32:0] Q30_TWO_PI    = 33'd6746518852;
    localparam logic [32:0] Q30_HALF_PI   = 33'd1686629713;
    localparam logic [32:0] Q30_PI        = 33'd3373259426;
    localparam logic [32:0] Q30_3HALF_PI  = 33'd5059889139;
    localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
    localparam logic [23:0] ANG_TWO_PI    = 24'd411775;
    localparam logic [23:0] ANG_FOUR_DEG  = 24'd4576;
    localparam int          DIV_STEPS     = 33;
    localparam int          HORNER_STEPS  = 8;

    localparam logic [1:0] KIND_PIE    = 2'd0;
    localparam logic [1:0] KIND_OPEN   = 2'd1;
    localparam logic [1:0] KIND_CLOSED = 2'd2;
    localparam logic [1:0] KIND_ALIAS  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_RED,
        ST_LEAD,
        ST_ARC,
        ST_TAIL
    } t_seq_state;

    typedef struct packed {
        logic               is_center;
        logic               last;
        logic [32:0]        ang;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        rad;
    } t_cmd;

    typedef struct packed {
        logic               is_center;
        logic               last;
        logic [1:0]         quad;
        logic [30:0]        x;
        logic [31:0]        x2;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        rad;
    } t_meta;

endpackage

/* design/acv_if.sv */
`timescale 1ns / 1ps
// Handshake interfaces for the arc request channel and the vertex channel.
// Stand-alone; the field widths follow the request and vertex formats.
interface acv_req_if;
    logic               valid;
    logic               ready;
    logic               fill_mode;
    logic [1:0]         arc_kind;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius;
    logic signed [23:0] start_angle;
    logic signed [23:0] end_angle;
    logic [5:0]         segment_count;

    modport source (
        output valid, fill_mode, arc_kind, center_x, center_y, radius,
               start_angle, end_angle, segment_count,
        input  ready
    );
    modport sink (
        input  valid, fill_mode, arc_kind, center_x, center_y, radius,
               start_angle, end_angle, segment_count,
        output ready
    );
endinterface

interface acv_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               last_vertex;

    modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
    modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

/* design/acv_seq.sv */
`timescale 1ns / 1ps
// Request sequencer: step division, start angle reduction and vertex commands.
// Depends on acv_pkg and acv_req_if.
module acv_seq
    import acv_pkg::*;
#(
    parameter int MAX_POINTS = 61
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    acv_req_if.sink        i_req,
    input  logic           i_ce,
    output logic           o_cmd_valid,
    output t_cmd           o_cmd
);

    localparam logic signed [39:0] TWO_PI_X32 = $signed(40'(Q30_TWO_PI) << 5);

    t_seq_state r_state, n_state;
    logic               r_fill, n_fill;
    logic [1:0]         r_kind, n_kind;
    logic signed [31:0] r_cx, n_cx, r_cy, n_cy;
    logic [30:0]        r_rad, n_rad;
    logic signed [23:0] r_a1, n_a1, r_a2, n_a2;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_full, n_full;
    logic               r_neg, n_neg;
    logic               r_small, n_small;
    logic [32:0]        r_num, n_num;
    logic [6:0]         r_rem, n_rem;
    logic [5:0]         r_bit, n_bit;
    logic [2:0]         r_k, n_k;
    logic signed [39:0] r_ang, n_ang;
    logic signed [33:0] r_step, n_step;
    logic [32:0]        r_ang0, n_ang0;
    logic [32:0]        r_cur, n_cur;
    logic [5:0]         r_idx, n_idx;
    logic [5:0]         r_npts, n_npts;
    logic               r_lead, n_lead;

    logic signed [24:0] w_diff;
    logic signed [24:0] w_ndiff;
    logic [23:0]        w_ad;
    logic               w_full;
    logic [6:0]         w_rs;
    logic               w_ge;
    logic [33:0]        w_smag;
    logic [1:0]         w_kind;
    logic signed [39:0] w_thr;
    logic signed [34:0] w_sum;
    logic [32:0]        w_next_cur;
    logic               w_has_tail;
    logic               w_tail_ctr;
    logic               w_arc_end;

    always_comb begin
        w_diff     = {r_a2[23], r_a2} - {r_a1[23], r_a1};
        w_ndiff    = -w_diff;
        w_ad       = w_diff[24] ? w_ndiff[23:0] : w_diff[23:0];
        w_full     = (w_ad >= ANG_TWO_PI);
        w_rs       = {r_rem[5:0], r_num[32]};
        w_ge       = (w_rs >= {1'b0, r_cnt});
        w_smag     = {r_num[19:0], 14'd0};
        w_thr      = $signed(40'(Q30_TWO_PI) << r_k);
        w_sum      = $signed({2'b00, r_cur}) + 35'(r_step);
        w_has_tail = r_full || (r_kind != KIND_OPEN);
        w_tail_ctr = !r_full && (r_kind == KIND_PIE);
        w_arc_end  = (r_idx == r_npts);
        w_kind     = r_kind;
        if (!r_fill && r_kind == KIND_CLOSED && r_small) begin
            w_kind = KIND_OPEN;
        end
        if (r_fill && r_kind == KIND_OPEN) begin
            w_kind = KIND_CLOSED;
        end
        if (w_sum < 0) begin
            w_next_cur = 33'(w_sum + 35'(Q30_TWO_PI));
        end else if (w_sum >= $signed({2'b00, Q30_TWO_PI})) begin
            w_next_cur = 33'(w_sum - 35'(Q30_TWO_PI));
        end else begin
            w_next_cur = w_sum[32:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_cnt == 6'd0 || r_a1 == r_a2) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_bit == 6'd1) begin
                    n_state = ST_RED;
                end
            end
            ST_RED: begin
                if (r_k == 3'd6 && r_num == 33'd0 && !r_full) begin
                    n_state = ST_IDLE;
                end else if (r_k == 3'd0) begin
                    n_state = r_lead ? ST_LEAD : ST_ARC;
                end
            end
            ST_LEAD: begin
                if (i_ce) begin
                    n_state = ST_ARC;
                end
            end
            ST_ARC: begin
                if (i_ce && w_arc_end) begin
                    n_state = w_has_tail ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (i_ce) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_fill  = r_fill;
        n_kind  = r_kind;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_rad   = r_rad;
        n_a1    = r_a1;
        n_a2    = r_a2;
        n_cnt   = r_cnt;
        n_full  = r_full;
        n_neg   = r_neg;
        n_small = r_small;
        n_num   = r_num;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_k     = r_k;
        n_ang   = r_ang;
        n_step  = r_step;
        n_ang0  = r_ang0;
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_npts  = r_npts;
        n_lead  = r_lead;
        case (r_state)
            ST_IDLE: begin
                n_fill = i_req.fill_mode;
                n_kind = (i_req.arc_kind == KIND_ALIAS) ? KIND_CLOSED : i_req.arc_kind;
                n_cx   = i_req.center_x;
                n_cy   = i_req.center_y;
                n_rad  = i_req.radius;
                n_a1   = i_req.start_angle;
                n_a2   = i_req.end_angle;
                n_cnt  = (i_req.segment_count > 6'(MAX_POINTS)) ? 6'(MAX_POINTS)
                                                                 : i_req.segment_count;
            end
            ST_CHECK: begin
                n_full  = w_full;
                n_neg   = w_diff[24];
                n_small = (w_ad < ANG_FOUR_DEG);
                n_num   = w_full ? Q30_TWO_PI + 33'(r_cnt[5:1])
                                 : 33'(w_ad) + 33'(r_cnt[5:1]);
                n_rem   = '0;
                n_bit   = 6'(DIV_STEPS);
                n_k     = 3'd6;
                n_ang   = w_full ? '0 : (40'(r_a1) <<< 14);
            end
            ST_DIV: begin
                n_rem = w_ge ? (w_rs - {1'b0, r_cnt}) : w_rs;
                n_num = {r_num[31:0], w_ge};
                n_bit = r_bit - 6'd1;
            end
            ST_RED: begin
                n_k = r_k - 3'd1;
                if (r_k == 3'd6) begin
                    if (r_ang < 0) begin
                        n_ang = r_ang + TWO_PI_X32;
                    end
                    if (r_full) begin
                        n_step = $signed({1'b0, r_num});
                        n_npts = r_cnt - 6'd1;
                        n_lead = r_fill;
                    end else begin
                        n_step = r_neg ? -$signed(w_smag) : $signed(w_smag);
                        n_npts = r_cnt;
                        n_lead = (w_kind == KIND_PIE);
                        n_kind = w_kind;
                    end
                end else if (r_ang >= w_thr) begin
                    n_ang = r_ang - w_thr;
                end
                if (r_k == 3'd0) begin
                    n_ang0 = n_ang[32:0];
                    n_cur  = n_ang[32:0];
                    n_idx  = '0;
                end
            end
            ST_ARC: begin
                if (i_ce) begin
                    n_cur = w_next_cur;
                    n_idx = r_idx + 6'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        i_req.ready       = (r_state == ST_IDLE);
        o_cmd_valid       = (r_state == ST_LEAD) || (r_state == ST_ARC)
                            || (r_state == ST_TAIL);
        o_cmd.is_center   = (r_state == ST_LEAD) || (r_state == ST_TAIL && w_tail_ctr);
        o_cmd.last        = (r_state == ST_TAIL)
                            || (r_state == ST_ARC && w_arc_end && !w_has_tail);
        o_cmd.ang         = (r_state == ST_ARC) ? r_cur : r_ang0;
        o_cmd.cx          = r_cx;
        o_cmd.cy          = r_cy;
        o_cmd.rad         = r_rad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill  <= n_fill;
        r_kind  <= n_kind;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_rad   <= n_rad;
        r_a1    <= n_a1;
        r_a2    <= n_a2;
        r_cnt   <= n_cnt;
        r_full  <= n_full;
        r_neg   <= n_neg;
        r_small <= n_small;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
        r_k     <= n_k;
        r_ang   <= n_ang;
        r_step  <= n_step;
        r_ang0  <= n_ang0;
        r_cur   <= n_cur;
        r_idx   <= n_idx;
        r_npts  <= n_npts;
        r_lead  <= n_lead;
    end

endmodule

/* design/acv_trig.sv */
`timescale 1ns / 1ps
// Pipelined cosine and sine of a reduced Q.30 angle by Horner series.
// Depends on acv_pkg.
module acv_trig
    import acv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_cmd_valid,
    input  t_cmd                 i_cmd,
    output logic                 o_valid,
    output t_meta                o_meta,
    output logic [FRAC_BITS+1:0] o_c_mag,
    output logic                 o_c_neg,
    output logic [FRAC_BITS+1:0] o_s_mag,
    output logic                 o_s_neg
);

    localparam int TW = FRAC_BITS + 2;
    localparam int SH = 30 - FRAC_BITS;
    localparam int NS = 4 + 2 * HORNER_STEPS;
    localparam logic [32:0] HALF = 33'd1 << (SH - 1);

    function automatic logic [30:0] sub_floor(input logic [31:0] q);
        return (q < 32'(Q30_ONE)) ? 31'(32'(Q30_ONE) - q) : '0;
    endfunction

    logic [NS-1:0] r_v;
    t_meta         r_m [NS];
    logic [31:0]   r_pc [HORNER_STEPS];
    logic [31:0]   r_qc [HORNER_STEPS];
    logic [31:0]   r_ps [1:HORNER_STEPS-1];
    logic [31:0]   r_qs [1:HORNER_STEPS-1];
    logic [30:0]   r_tc;
    logic [31:0]   r_xs;
    logic [TW-1:0] r_cm, r_sm;
    logic          r_cn, r_sn;

    t_meta         w_m0, w_m1;
    logic [1:0]    w_quad;
    logic [32:0]   w_base;
    logic [32:0]   w_x;
    logic [61:0]   w_xx;
    logic [30:0]   w_tc_f, w_ts_f;
    logic [61:0]   w_xs;
    logic [32:0]   w_cr, w_sr;
    logic [TW-1:0] w_c, w_s;

    always_comb begin
        if (i_cmd.ang >= Q30_3HALF_PI) begin
            w_quad = 2'd3;
            w_base = Q30_3HALF_PI;
        end else if (i_cmd.ang >= Q30_PI) begin
            w_quad = 2'd2;
            w_base = Q30_PI;
        end else if (i_cmd.ang >= Q30_HALF_PI) begin
            w_quad = 2'd1;
            w_base = Q30_HALF_PI;
        end else begin
            w_quad = 2'd0;
            w_base = '0;
        end
        w_x            = i_cmd.ang - w_base;
        w_m0.is_center = i_cmd.is_center;
        w_m0.last      = i_cmd.last;
        w_m0.quad      = w_quad;
        w_m0.x         = w_x[30:0];
        w_m0.x2        = '0;
        w_m0.cx        = i_cmd.cx;
        w_m0.cy        = i_cmd.cy;
        w_m0.rad       = i_cmd.rad;
        w_xx           = r_m[0].x * r_m[0].x;
        w_m1           = r_m[0];
        w_m1.x2        = w_xx[61:30];
    end

    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
        localparam int K = HORNER_STEPS - j;
        localparam int DC = (2 * K - 1) * (2 * K);
        localparam int SC = 32 + $clog2(DC);
        localparam logic [63:0] MC64 = ((64'd1 << SC) + 64'(DC) - 64'd1) / 64'(DC);
        localparam logic [32:0] MC = MC64[32:0];

        logic [30:0] w_tc;
        logic [62:0] w_pc;
        logic [64:0] w_qc;

        if (j == 0) begin : g_first
            assign w_tc = Q30_ONE;
        end else begin : g_next
            assign w_tc = sub_floor(r_qc[j-1]);
        end
        assign w_pc = r_m[1+2*j].x2 * w_tc;
        assign w_qc = r_pc[j] * MC;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_pc[j] <= w_pc[61:30];
                r_qc[j] <= w_qc[SC +: 32];
            end
        end

        if (j > 0) begin : g_sin
            localparam int DS = (2 * K) * (2 * K + 1);
            localparam int SS = 32 + $clog2(DS);
            localparam logic [63:0] MS64 = ((64'd1 << SS) + 64'(DS) - 64'd1) / 64'(DS);
            localparam logic [32:0] MS = MS64[32:0];

            logic [30:0] w_ts;
            logic [62:0] w_ps;
            logic [64:0] w_qs;

            if (j == 1) begin : g_first
                assign w_ts = Q30_ONE;
            end else begin : g_next
                assign w_ts = sub_floor(r_qs[j-1]);
            end
            assign w_ps = r_m[1+2*j].x2 * w_ts;
            assign w_qs = r_ps[j] * MS;

            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_ps[j] <= w_ps[61:30];
                    r_qs[j] <= w_qs[SS +: 32];
                end
            end
        end
    end

    always_comb begin
        w_tc_f = sub_floor(r_qc[HORNER_STEPS-1]);
        w_ts_f = sub_floor(r_qs[HORNER_STEPS-1]);
        w_xs   = r_m[NS-3].x * w_ts_f;
        w_cr   = {2'b00, r_tc} + HALF;
        w_sr   = {1'b0, r_xs} + HALF;
        w_c    = w_cr[SH +: TW];
        w_s    = w_sr[SH +: TW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[NS-2:0], i_cmd_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_m[0] <= w_m0;
            for (int s = 2; s < NS; s++) begin
                r_m[s] <= r_m[s-1];
            end
            r_m[1] <= w_m1;
            r_tc   <= w_tc_f;
            r_xs   <= w_xs[61:30];
            case (r_m[NS-2].quad)
                2'd0: begin
                    r_cm <= w_c;
                    r_cn <= 1'b0;
                    r_sm <= w_s;
                    r_sn <= 1'b0;
                end
                2'd1: begin
                    r_cm <= w_s;
                    r_cn <= 1'b1;
                    r_sm <= w_c;
                    r_sn <= 1'b0;
                end
                2'd2: begin
                    r_cm <= w_c;
                    r_cn <= 1'b1;
                    r_sm <= w_s;
                    r_sn <= 1'b1;
                end
                default: begin
                    r_cm <= w_s;
                    r_cn <= 1'b0;
                    r_sm <= w_c;
                    r_sn <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_meta  = r_m[NS-1];
    assign o_c_mag = r_cm;
    assign o_c_neg = r_cn;
    assign o_s_mag = r_sm;
    assign o_s_neg = r_sn;

endmodule

/* design/acv_place.sv */
`timescale 1ns / 1ps
// Scales cosine and sine by the radius, adds the centre and saturates.
// Depends on acv_pkg and acv_vtx_if; holds the output register.
module acv_place
    import acv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ce,
    input  logic                 i_valid,
    input  t_meta                i_meta,
    input  logic [FRAC_BITS+1:0] i_c_mag,
    input  logic                 i_c_neg,
    input  logic [FRAC_BITS+1:0] i_s_mag,
    input  logic                 i_s_neg,
    acv_vtx_if.source            o_vtx
);

    localparam int PW = 31 + FRAC_BITS + 2;
    localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [34:0] SAT_HI = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] SAT_LO = -35'sh0_8000_0000;

    function automatic logic [31:0] place(input logic signed [31:0] c,
                                          input logic [PW-1:0] prod,
                                          input logic neg);
        logic [PW:0]         rnd;
        logic signed [34:0]  mag;
        logic signed [34:0]  sum;
        rnd = {1'b0, prod} + HALF;
        mag = $signed(35'(rnd[PW:FRAC_BITS]));
        sum = neg ? (35'(c) - mag) : (35'(c) + mag);
        if (sum > SAT_HI) begin
            return SAT_HI[31:0];
        end else if (sum < SAT_LO) begin
            return SAT_LO[31:0];
        end
        return sum[31:0];
    endfunction

    logic               r_v1;
    logic [PW-1:0]      r_px, r_py;
    logic               r_xn, r_yn;
    logic               r_ctr, r_last;
    logic signed [31:0] r_cx, r_cy;
    logic               r_ov;
    logic signed [31:0] r_ox, r_oy;
    logic               r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_ce) begin
            r_v1 <= i_valid;
            r_ov <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_px    <= i_meta.rad * i_c_mag;
            r_py    <= i_meta.rad * i_s_mag;
            r_xn    <= i_c_neg;
            r_yn    <= i_s_neg;
            r_ctr   <= i_meta.is_center;
            r_last  <= i_meta.last;
            r_cx    <= i_meta.cx;
            r_cy    <= i_meta.cy;
            r_ox    <= r_ctr ? r_cx : place(r_cx, r_px, r_xn);
            r_oy    <= r_ctr ? r_cy : place(r_cy, r_py, r_yn);
            r_olast <= r_last;
        end
    end

    assign o_vtx.valid       = r_ov;
    assign o_vtx.vertex_x    = r_ox;
    assign o_vtx.vertex_y    = r_oy;
    assign o_vtx.last_vertex = r_olast;

endmodule

/* design/arc_ellipse_vertex_generator.sv */
`timescale 1ns / 1ps
// Channel   Dir  Beat                                   Accepted when
// i_req     in   one arc request                        valid && ready
// o_vtx     out  one vertex, last_vertex ends the list  valid && ready
// After a request is taken, the sequencer runs a check, a one-bit-per-cycle step
// division and start angle reduction before the first vertex is issued, then one
// vertex per cycle while o_vtx does not stall, up to 64. The sequencer takes the
// next request in the cycle after it has issued the last vertex.
// Issued vertices leave through the sine and cosine pipeline.
// Reset is synchronous and clears control state only.
// A stall on o_vtx freezes the whole pipeline and vertex issue.
module arc_ellipse_vertex_generator
    import acv_pkg::*;
#(
    parameter int MAX_POINTS = 61,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    acv_req_if.sink   i_req,
    acv_vtx_if.source o_vtx
);

    logic                 w_ce;
    logic                 w_cmd_valid;
    t_cmd                 w_cmd;
    logic                 w_tr_valid;
    t_meta                w_tr_meta;
    logic [FRAC_BITS+1:0] w_c_mag, w_s_mag;
    logic                 w_c_neg, w_s_neg;

    assign w_ce = !o_vtx.valid || o_vtx.ready;

    acv_seq #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_ce        (w_ce),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    acv_trig #(
        .FRAC_BITS (FRAC_BITS)
    ) u_trig (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ce        (w_ce),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_valid     (w_tr_valid),
        .o_meta      (w_tr_meta),
        .o_c_mag     (w_c_mag),
        .o_c_neg     (w_c_neg),
        .o_s_mag     (w_s_mag),
        .o_s_neg     (w_s_neg)
    );

    acv_place #(
        .FRAC_BITS (FRAC_BITS)
    ) u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_tr_valid),
        .i_meta  (w_tr_meta),
        .i_c_mag (w_c_mag),
        .i_c_neg (w_c_neg),
        .i_s_mag (w_s_mag),
        .i_s_neg (w_s_neg),
        .o_vtx   (o_vtx)
    );

`ifndef SYNTH
    a_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> !w_cmd_valid)
        else $error("Vertex issued while a request beat was taken.");

    a_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && !w_ce) |=> (w_cmd_valid && $stable(w_cmd)))
        else $error("Vertex command changed during a stall.");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd.last && w_ce) |=> !w_cmd_valid)
        else $error("Vertex command issued after the last vertex of a list.");
`endif

endmodule

/* tb/arc_ellipse_vertex_generator_checker.sv */
`timescale 1ns / 1ps
// Checker for the arc vertex generator: watches the request and vertex channels,
// predicts each vertex list and compares beat by beat. Depends on acv_pkg and acv_if.
module arc_ellipse_vertex_generator_checker
    import acv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    acv_req_if     req,
    acv_vtx_if     vtx,
    output int     o_fail_count,
    output int     o_pending
);

    localparam int  MAX_PTS = 61;
    localparam int  FRAC    = 16;
    localparam longint TWO_PI30  = 64'd6746518852;
    localparam longint HALF_PI30 = 64'd1686629713;
    localparam longint ONE30     = 64'd1 << 30;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               last;
    } t_vertex;

    t_vertex vertex_queue[$];
    int      fails;

    assign o_fail_count = fails;
    assign o_pending    = vertex_queue.size();

    function automatic longint floor_sub(longint a, longint b);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic longint round_frac(longint v30);
        return (v30 + (64'd1 << (30 - FRAC - 1))) >>> (30 - FRAC);
    endfunction

    function automatic void sin_cos(input longint ang, output longint co, output longint si);
        longint r, x, x2, ts, tc, s, c;
        int q;
        r = ang % TWO_PI30;
        if (r < 0) r += TWO_PI30;
        q = int'(r / HALF_PI30);
        if (q > 3) q = 3;
        x  = r - q * HALF_PI30;
        x2 = (x * x) >>> 30;
        ts = ONE30;
        for (int k = 7; k >= 1; k--)
            ts = floor_sub(ONE30, ((x2 * ts) >>> 30) / ((2 * k) * (2 * k + 1)));
        s = round_frac((x * ts) >>> 30);
        tc = ONE30;
        for (int k = 8; k >= 1; k--)
            tc = floor_sub(ONE30, ((x2 * tc) >>> 30) / ((2 * k - 1) * (2 * k)));
        c = round_frac(tc);
        case (q)
            0: begin co = c;  si = s;  end
            1: begin co = -s; si = c;  end
            2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
        endcase
    endfunction

    function automatic logic signed [31:0] place_coord(longint ctr, longint rad, longint t);
        longint mag, rnd, sum;
        mag = rad * (t < 0 ? -t : t);
        rnd = (mag + (64'd1 << (FRAC - 1))) >>> FRAC;
        sum = ctr + (t < 0 ? -rnd : rnd);
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    function automatic void push_vertex(logic signed [31:0] x, logic signed [31:0] y);
        t_vertex v;
        v.vx = x;
        v.vy = y;
        v.last = 1'b0;
        vertex_queue.push_back(v);
    endfunction

    function automatic void push_arc_point(longint cx, longint cy, longint rad, longint ang);
        longint co, si;
        sin_cos(ang, co, si);
        push_vertex(place_coord(cx, rad, co), place_coord(cy, rad, si));
    endfunction

    function automatic void predict_arc();
        logic       fill;
        logic [1:0] kind;
        longint     cx, cy, rad, a1, a2, cnt, diff, ad, smag, step, st30;
        int         first;
        fill = req.fill_mode;
        kind = req.arc_kind;
        cx   = req.center_x;
        cy   = req.center_y;
        rad  = req.radius;
        a1   = req.start_angle;
        a2   = req.end_angle;
        cnt  = req.segment_count;
        first = vertex_queue.size();
        if (kind == KIND_ALIAS) kind = KIND_CLOSED;
        if (cnt > MAX_PTS) cnt = MAX_PTS;
        if (cnt == 0 || a1 == a2) return;
        diff = a2 - a1;
        ad   = diff < 0 ? -diff : diff;
        if (ad >= longint'(ANG_TWO_PI)) begin
            st30 = (TWO_PI30 + cnt / 2) / cnt;
            if (fill) push_vertex(cx, cy);
            for (longint i = 0; i < cnt; i++) push_arc_point(cx, cy, rad, i * st30);
            push_arc_point(cx, cy, rad, 0);
        end else begin
            smag = (ad + cnt / 2) / cnt;
            step = diff < 0 ? -smag : smag;
            if (step == 0) return;
            if (!fill && kind == KIND_CLOSED && ad < longint'(ANG_FOUR_DEG)) kind = KIND_OPEN;
            if (fill && kind == KIND_OPEN) kind = KIND_CLOSED;
            if (kind == KIND_PIE) push_vertex(cx, cy);
            for (longint i = 0; i <= cnt; i++)
                push_arc_point(cx, cy, rad, (a1 + i * step) * 16384);
            if (kind == KIND_PIE) push_vertex(cx, cy);
            else if (kind == KIND_CLOSED) push_arc_point(cx, cy, rad, a1 * 16384);
        end
        if (vertex_queue.size() > first) vertex_queue[$].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_vertex want;
        if (!i_rst_n) begin
            fails <= 0;
            vertex_queue.delete();
        end else begin
            if (req.valid && req.ready) predict_arc();
            if (vtx.valid && vtx.ready) begin
                if (vertex_queue.size() == 0) begin
                    if (fails < 10)
                        $display("Unexpected vertex x=%0d y=%0d last=%0b",
                                 vtx.vertex_x, vtx.vertex_y, vtx.last_vertex);
                    fails <= fails + 1;
                end else begin
                    want = vertex_queue.pop_front();
                    if (want.vx !== vtx.vertex_x || want.vy !== vtx.vertex_y
                            || want.last !== vtx.last_vertex) begin
                        if (fails < 10)
                            $display("Vertex mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                     want.vx, want.vy, want.last,
                                     vtx.vertex_x, vtx.vertex_y, vtx.last_vertex);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/arc_ellipse_vertex_generator_test.sv */
`timescale 1ns / 1ps
// Top of the arc vertex generator testbench: clock, reset, request stimulus,
// vertex stalls and verdict. Depends on acv_pkg, acv_if, the generator and the checker.
module arc_ellipse_vertex_generator_test
    import acv_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    acv_req_if req ();
    acv_vtx_if vtx ();

    arc_ellipse_vertex_generator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_vtx   (vtx.source)
    );

    arc_ellipse_vertex_generator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req),
        .vtx          (vtx),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) vtx.ready <= 1'b0;
        else vtx.ready <= calm || ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req.valid && req.ready) || (vtx.valid && vtx.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [23:0] random_angle();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(2 * 411775))) - 24'sd411775;
            2: return $signed(24'($urandom_range(8000))) - 24'sd4000;
            default: return $signed(24'($urandom_range(60000))) - 24'sd30000;
        endcase
    endfunction

    task automatic send_arc(input logic fill, input logic [1:0] kind,
                            input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic [30:0] rad, input logic signed [23:0] a1,
                            input logic signed [23:0] a2, input logic [5:0] cnt);
        while (!calm && $urandom_range(99) < 13) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid         <= 1'b1;
        req.fill_mode     <= fill;
        req.arc_kind      <= kind;
        req.center_x      <= cx;
        req.center_y      <= cy;
        req.radius        <= rad;
        req.start_angle   <= a1;
        req.end_angle     <= a2;
        req.segment_count <= cnt;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    task automatic send_random_arc();
        logic [5:0] cnt;
        logic [30:0] rad;
        cnt = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(1, 8));
        rad = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 22));
        send_arc(1'($urandom), 2'($urandom), 32'($urandom), 32'($urandom), rad,
                 random_angle(), random_angle(), cnt);
    endtask

    initial begin
        i_rst_n = 1'b0;
        calm = 1'b0;
        req.valid = 1'b0;
        req.fill_mode = 1'b0;
        req.arc_kind = KIND_PIE;
        req.center_x = '0;
        req.center_y = '0;
        req.radius = '0;
        req.start_angle = '0;
        req.end_angle = '0;
        req.segment_count = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_arc(1'b0, KIND_PIE, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF,
                 24'sd0, 24'sd102944, 6'd4);
        send_arc(1'b1, KIND_OPEN, 32'sd0, 32'sd0, 31'h0001_0000, 24'sd0, 24'sd411775, 6'd0);
        send_arc(1'b0, KIND_OPEN, 32'sd0, 32'sd0, 31'h0001_0000, 24'sd1000, 24'sd1000, 6'd5);
        send_arc(1'b0, KIND_CLOSED, 32'sd0, 32'sd0, 31'h0001_0000, 24'sd0, 24'sd411775, 6'd6);
        send_arc(1'b1, KIND_CLOSED, 32'sh100, -32'sh100, 31'h0001_0000,
                 24'sh7FFFFF, 24'sh800000, 6'd63);
        send_arc(1'b0, KIND_CLOSED, 32'sd0, 32'sd0, 31'h0010_0000, 24'sd0, 24'sd4575, 6'd3);
        send_arc(1'b0, KIND_CLOSED, 32'sd0, 32'sd0, 31'h0010_0000, 24'sd0, -24'sd4576, 6'd3);
        send_arc(1'b1, KIND_OPEN, 32'sd0, 32'sd0, 31'h0010_0000, 24'sd100, 24'sd2000, 6'd2);
        send_arc(1'b1, KIND_PIE, 32'sd0, 32'sd0, 31'h0010_0000, -24'sd50000, 24'sd50000,
                 6'd61);
        send_arc(1'b0, KIND_ALIAS, 32'sd0, 32'sd0, 31'h0010_0000, 24'sd0, 24'sd20000, 6'd1);
        send_arc(1'b0, KIND_OPEN, 32'sd0, 32'sd0, 31'h0010_0000, 24'sd0, 24'sd10, 6'd30);
        send_arc(1'b1, KIND_OPEN, 32'sd0, 32'sd0, 31'h0000_0000, 24'sd5, -24'sd411776, 6'd1);
        send_arc(1'b0, KIND_PIE, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                 24'sd300000, 24'sd100000, 6'd7);

        calm = 1'b1;
        req.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        for (int i = 0; i < 120; i++) send_random_arc();
        calm = 1'b0;
        for (int i = 0; i < 337; i++) begin
            if (i == 150) begin
                req.valid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            send_random_arc();
        end

        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
